// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DLRR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dlrr: assertion failed");

// Clocked assertion that is also checked during reset.
`define DLRR_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("dlrr: assertion failed");

`endif

// File: sv/dlrr_pkg.sv
// ---------------------------------------------------------------------------
// dlrr_pkg
// Types, register indexes and constants of the dual LFSR random generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlrr_pkg;

   // Default number of random bits kept from the combined registers.
   localparam int KEEP_BITS_DEFAULT = 16;

   // Widths of the fixed fields.
   localparam int LFSR_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int RANGE_W    = 16;
   localparam int SPAN_W     = 17;
   localparam int VALUE_W    = 17;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED_LONG  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED_SHORT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_LONG  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_SHORT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_MIN  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_MAX  = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [LFSR_W-1:0]  MASK_LONG_RESET  = 32'hB4BC_D35C;
   localparam logic [LFSR_W-1:0]  MASK_SHORT_RESET = 32'h7A5B_C2E3;
   localparam logic [RANGE_W-1:0] RANGE_MIN_RESET  = 16'd0;
   localparam logic [RANGE_W-1:0] RANGE_MAX_RESET  = 16'd500;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ADD,
      ST_DONE
   } state_type;

   // Control from the top level to the LFSR pair.
   typedef struct packed {
      logic load_long;
      logic load_short;
      logic step;
   } lfsr_ctrl_type;

endpackage

`default_nettype wire

// File: sv/dual_lfsr_ranged_random.sv
// Sequence: a draw with a usable range passes the remainder unit, the offset add
// and the output register; an unseeded draw goes straight to the output register,
// an inverted range skips the remainder. A new draw is taken only once the last
// result has entered the output register; the remainder unit takes one dividend bit per cycle.
// Reset: synchronous and active high; it clears both LFSRs, the seeded flag and
// the handshake state, and restores the tap masks and range bounds.
// ---------------------------------------------------------------------------
// dual_lfsr_ranged_random
// Ranged random draws from two combined Galois LFSRs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_lfsr_ranged_random #(
   parameter int KEEP_BITS = dlrr_pkg::KEEP_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Draw requests
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [dlrr_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] draw
   // Results
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [dlrr_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [16:0] value
   // Configuration
   input  wire logic                              csr_we,
   input  wire logic [dlrr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [dlrr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dlrr_pkg::*;

   state_type          state_ff, state_in;
   logic [LFSR_W-1:0]  mask_long_ff, mask_short_ff;
   logic [RANGE_W-1:0] range_min_ff, range_max_ff;
   logic [VALUE_W-1:0] op_ff, op_in;
   logic               use_rem_ff, use_rem_in;
   logic [VALUE_W-1:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   lfsr_ctrl_type        lfsr_ctrl;
   logic [KEEP_BITS-1:0] v_next;
   logic [32:0]          v_wide;
   logic                 seeded;
   logic                 div_start, div_busy;
   logic [SPAN_W-1:0]    span, remainder;
   logic                 req_xfer, draw_xfer, inverted, rsp_load;

   // Configuration registers; seed writes go straight to the LFSRs.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_long_ff  <= MASK_LONG_RESET;
         mask_short_ff <= MASK_SHORT_RESET;
         range_min_ff  <= RANGE_MIN_RESET;
         range_max_ff  <= RANGE_MAX_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MASK_LONG:  mask_long_ff  <= csr_wdata;
            CSR_MASK_SHORT: mask_short_ff <= csr_wdata;
            CSR_RANGE_MIN:  range_min_ff  <= csr_wdata[RANGE_W-1:0];
            CSR_RANGE_MAX:  range_max_ff  <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // Decode of the request transfer.
   always_comb begin
      req_tready           = (state_ff == ST_IDLE);
      req_xfer             = req_tvalid && req_tready;
      draw_xfer            = req_xfer && req_tdata[0];
      inverted             = (range_max_ff < range_min_ff);
      span                 = SPAN_W'(range_max_ff) - SPAN_W'(range_min_ff) + 1'b1;
      v_wide               = 33'(v_next);
      lfsr_ctrl.load_long  = csr_we && (csr_addr == CSR_SEED_LONG);
      lfsr_ctrl.load_short = csr_we && (csr_addr == CSR_SEED_SHORT);
      lfsr_ctrl.step       = draw_xfer && seeded;
      div_start            = draw_xfer && seeded && !inverted;
   end

   dlrr_lfsr #(
      .KEEP_BITS (KEEP_BITS)
   ) u_lfsr (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lfsr_ctrl),
      .seed       (csr_wdata),
      .mask_long  (mask_long_ff),
      .mask_short (mask_short_ff),
      .v_next     (v_next),
      .seeded     (seeded)
   );

   dlrr_modulo #(
      .KEEP_BITS (KEEP_BITS)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (v_next),
      .span      (span),
      .busy      (div_busy),
      .remainder (remainder)
   );

   // Sequencer: remainder and offset add where needed, then hand-over to the output register.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      use_rem_in = use_rem_ff;
      res_in     = res_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (draw_xfer) begin
               op_in      = v_wide[VALUE_W-1:0];
               use_rem_in = !inverted;
               if (!seeded) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else if (inverted) begin
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (use_rem_ff) begin
               res_in = remainder + VALUE_W'(range_min_ff);
            end else begin
               res_in = op_ff + VALUE_W'(range_min_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      use_rem_ff <= use_rem_in;
      res_ff     <= res_in;
   end

   // Output register: a finished result waits here for its transfer.
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_value_in = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);

endmodule

`default_nettype wire

// File: sv/dlrr_lfsr.sv
// ---------------------------------------------------------------------------
// dlrr_lfsr
// Long and short Galois LFSRs with seed loading, seeded flag and draw value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlrr_lfsr #(
   parameter int KEEP_BITS = dlrr_pkg::KEEP_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dlrr_pkg::lfsr_ctrl_type       ctrl,
   input  wire logic [dlrr_pkg::LFSR_W-1:0]   seed,
   input  wire logic [dlrr_pkg::LFSR_W-1:0]   mask_long,
   input  wire logic [dlrr_pkg::LFSR_W-1:0]   mask_short,
   output logic      [KEEP_BITS-1:0]          v_next,
   output logic                               seeded
);
   import dlrr_pkg::*;

   logic [LFSR_W-1:0] long_ff, long_in;
   logic [LFSR_W-1:0] short_ff, short_in;
   logic [LFSR_W-1:0] long_step, short_step, combined;
   logic              seeded_ff, seeded_in;

   // One right shift; the taps are folded in when a one drops out.
   function automatic logic [LFSR_W-1:0] galois_shift(input logic [LFSR_W-1:0] r,
                                                       input logic [LFSR_W-1:0] taps);
      logic [LFSR_W-1:0] s;
      s = r >> 1;
      if (r[0]) begin
         s = s ^ taps;
      end
      return s;
   endfunction

   // The long register advances twice per draw, the short one once.
   always_comb begin
      long_step  = galois_shift(galois_shift(long_ff, mask_long), mask_long);
      short_step = galois_shift(short_ff, mask_short);
      combined   = long_step ^ short_step;
      v_next     = combined[KEEP_BITS-1:0];
   end

   // Seed loads take priority over a draw step.
   always_comb begin
      long_in   = long_ff;
      short_in  = short_ff;
      seeded_in = seeded_ff;
      if (ctrl.load_long) begin
         long_in   = seed;
         seeded_in = 1'b1;
      end else if (ctrl.step) begin
         long_in = long_step;
      end
      if (ctrl.load_short) begin
         short_in  = seed;
         seeded_in = 1'b1;
      end else if (ctrl.step) begin
         short_in = short_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff   <= '0;
         short_ff  <= '0;
         seeded_ff <= 1'b0;
      end else begin
         long_ff   <= long_in;
         short_ff  <= short_in;
         seeded_ff <= seeded_in;
      end
   end

   assign seeded = seeded_ff;

endmodule

`default_nettype wire

// File: sv/dlrr_modulo.sv
// ---------------------------------------------------------------------------
// dlrr_modulo
// Bit-serial restoring remainder: one dividend bit enters per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlrr_modulo #(
   parameter int KEEP_BITS = dlrr_pkg::KEEP_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [KEEP_BITS-1:0]          dividend,
   input  wire logic [dlrr_pkg::SPAN_W-1:0]   span,
   output logic                               busy,
   output logic      [dlrr_pkg::SPAN_W-1:0]   remainder
);
   import dlrr_pkg::*;

   localparam int CNT_W = $clog2(KEEP_BITS + 1);

   logic [KEEP_BITS-1:0] dividend_ff, dividend_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [SPAN_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SPAN_W:0]      rem_shift, rem_diff;

   // Shift the next dividend bit into the partial remainder and subtract
   // the span when it fits.
   always_comb begin
      rem_shift   = {rem_ff, dividend_ff[KEEP_BITS-1]};
      rem_diff    = rem_shift - {1'b0, span_ff};
      dividend_in = dividend_ff;
      span_in     = span_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      if (start) begin
         dividend_in = dividend;
         span_in     = span;
         rem_in      = '0;
         count_in    = CNT_W'(KEEP_BITS);
      end else if (count_ff != '0) begin
         dividend_in = dividend_ff << 1;
         if (rem_shift >= {1'b0, span_ff}) begin
            rem_in = rem_diff[SPAN_W-1:0];
         end else begin
            rem_in = rem_shift[SPAN_W-1:0];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: sv/dlrr_checker.sv
// ---------------------------------------------------------------------------
// dlrr_port_checks
// Port-level checks of the ranged random generator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dlrr_port_checks (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [dlrr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [dlrr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                              csr_we,
   input wire logic [dlrr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input wire logic [dlrr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dlrr_pkg::*;

   logic [RSP_DATA_W-VALUE_W-1:0] rsp_pad;
   logic                          cfg_seen;

   assign rsp_pad  = rsp_tdata[RSP_DATA_W-1:VALUE_W];
   assign cfg_seen = csr_we && (csr_addr == CSR_SEED_LONG) && (csr_wdata == csr_wdata);

   // A waiting result holds its value until it is taken.
   `DLRR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // The padding above the value is always zero.
   `DLRR_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_pad == '0)

   // Reset leaves no result pending.
   `DLRR_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // A request without a draw never produces a result.
   `DLRR_ASSERT(a_no_draw, clock, reset, req_tvalid && req_tready && !req_tdata[0] && !rsp_tvalid && !cfg_seen |=> !rsp_tvalid)

   // A draw keeps the request side closed while it is worked on.
   `DLRR_ASSERT(a_draw_busy, clock, reset, req_tvalid && req_tready && req_tdata[0] |=> !req_tready)

endmodule

bind dual_lfsr_ranged_random dlrr_port_checks u_checker (.*);

`default_nettype wire

// File: test/dlrr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlrr_checker
// Watches the draw, result and register ports of the dual LFSR random
// generator. It keeps its own copy of both shift registers and the settings,
// works out the value each accepted draw should return, and compares every
// result transfer with the oldest value still outstanding.
// ---------------------------------------------------------------------------

module dlrr_checker
   import dlrr_pkg::*;
#(
   parameter int KEEP_BITS = KEEP_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // [0] draw
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,    // [16:0] value
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    errors,
   output int                    draws_checked
);

   localparam logic [LFSR_W-1:0] KEEP_MASK = LFSR_W'((64'd1 << KEEP_BITS) - 64'd1);

   // Shadow copy of the generator state and its settings.
   logic [LFSR_W-1:0]  long_lfsr;
   logic [LFSR_W-1:0]  short_lfsr;
   logic [LFSR_W-1:0]  taps_long;
   logic [LFSR_W-1:0]  taps_short;
   logic [RANGE_W-1:0] range_lo;
   logic [RANGE_W-1:0] range_hi;
   logic               seeded;

   // Values still owed by the block, oldest first.
   logic [VALUE_W-1:0] owed_values[$];

   // One right shift of a Galois register; the taps go in when a 1 drops out.
   function automatic logic [LFSR_W-1:0] galois_shift(input logic [LFSR_W-1:0] bits,
                                                      input logic [LFSR_W-1:0] taps);
      return bits[0] ? ((bits >> 1) ^ taps) : (bits >> 1);
   endfunction

   // Advances the shadow registers by one draw and returns the scaled value.
   function automatic logic [VALUE_W-1:0] scaled_draw();
      logic [LFSR_W-1:0] raw;
      logic [SPAN_W-1:0] span;
      logic [32:0]       total;
      if (!seeded)
         return '0;
      long_lfsr  = galois_shift(galois_shift(long_lfsr, taps_long), taps_long);
      short_lfsr = galois_shift(short_lfsr, taps_short);
      raw = (long_lfsr ^ short_lfsr) & KEEP_MASK;
      // An inverted range means no limit: only the offset is added.
      if (range_hi < range_lo) begin
         total = 33'(raw) + 33'(range_lo);
      end else begin
         span  = SPAN_W'(range_hi) - SPAN_W'(range_lo) + 1'b1;
         total = 33'(raw % span) + 33'(range_lo);
      end
      return total[VALUE_W-1:0];
   endfunction

   // Follow register writes and transfers on both channels.
   always @(posedge clock) begin
      logic [VALUE_W-1:0] want;
      logic [VALUE_W-1:0] got;
      if (reset) begin
         long_lfsr  = '0;
         short_lfsr = '0;
         taps_long  = MASK_LONG_RESET;
         taps_short = MASK_SHORT_RESET;
         range_lo   = RANGE_MIN_RESET;
         range_hi   = RANGE_MAX_RESET;
         seeded     = 1'b0;
         owed_values.delete();
         pending       <= 0;
         errors        <= 0;
         draws_checked <= 0;
      end else begin
         // Writes to indexes beyond the register list change nothing.
         if (csr_we) begin
            case (csr_addr)
               CSR_SEED_LONG: begin
                  long_lfsr = csr_wdata;
                  seeded    = 1'b1;
               end
               CSR_SEED_SHORT: begin
                  short_lfsr = csr_wdata;
                  seeded     = 1'b1;
               end
               CSR_MASK_LONG:  taps_long  = csr_wdata;
               CSR_MASK_SHORT: taps_short = csr_wdata;
               CSR_RANGE_MIN:  range_lo   = csr_wdata[RANGE_W-1:0];
               CSR_RANGE_MAX:  range_hi   = csr_wdata[RANGE_W-1:0];
               default: ;
            endcase
         end

         // A request without the draw bit owes nothing.
         if (req_tvalid && req_tready && req_tdata[0])
            owed_values.push_back(scaled_draw());

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[VALUE_W-1:0];
            if (owed_values.size() == 0) begin
               $error("value: result transfer %0d arrived with nothing outstanding", got);
               errors <= errors + 1;
            end else begin
               want = owed_values.pop_front();
               draws_checked <= draws_checked + 1;
               if (got !== want) begin
                  $error("value mismatch: expected %0d, actual %0d", want, got);
                  errors <= errors + 1;
               end
            end
         end

         pending <= owed_values.size();
      end
   end

endmodule

// File: test/tb_dual_lfsr_ranged_random.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dual_lfsr_ranged_random
// Drives draw requests and register writes into the dual LFSR random
// generator: a directed opening over the unseeded state, ignored register
// indexes and the range extremes, then randomised settings with random
// idling on both sides and one long result stall. The checker beside the
// block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------

module tb_dual_lfsr_ranged_random;
   import dlrr_pkg::*;

   localparam int KEEP_BITS       = KEEP_BITS_DEFAULT;
   localparam int DRAW_LATENCY    = KEEP_BITS + 4;
   localparam int SETTLE_CYCLES   = 2 * DRAW_LATENCY;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_PERCENT    = 31;
   localparam int BLANK_PERCENT   = 15;
   localparam int RANDOM_PHASES   = 8;
   localparam int DRAWS_PER_PHASE = 210;
   localparam int STALL_PHASE     = 1;
   localparam int BUSY_PHASE      = 3;

   // Indexes past the end of the register list; writes there do nothing.
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [0] draw
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [16:0] value
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int pending;
   int errors;
   int draws_checked;

   int  cycle_count = 0;
   int  hold_count = 0;
   int  draws_sent = 0;
   int  blanks_sent = 0;
   int  settings_used = 0;
   bit  no_idle = 1'b0;
   bit  hold_req = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   dual_lfsr_ranged_random #(
      .KEEP_BITS (KEEP_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dlrr_checker #(
      .KEEP_BITS (KEEP_BITS)
   ) u_checker (.*);

   // Result side: random back-pressure, plus one long hold-off once asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offers one request, after a random gap, and returns once it is taken.
   task automatic send_request(input logic draw);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'(draw);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (draw)
         draws_sent++;
      else
         blanks_sent++;
   endtask

   task automatic send_draws(input int count);
      repeat (count) send_request(1'b1);
   endtask

   // Lets every owed result drain, then covers any request still in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // A 32-bit word that favours the extremes.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   // Random settings between phases; the upper bits of range writes are junk.
   task automatic randomise_settings();
      logic [RANGE_W-1:0] lo;
      logic [RANGE_W-1:0] hi;
      if ($urandom_range(99) < 70) write_reg(CSR_SEED_LONG, pick_word());
      if ($urandom_range(99) < 70) write_reg(CSR_SEED_SHORT, pick_word());
      if ($urandom_range(99) < 40) write_reg(CSR_MASK_LONG, pick_word());
      if ($urandom_range(99) < 40) write_reg(CSR_MASK_SHORT, pick_word());
      case ($urandom_range(4))
         0: begin
            lo = RANGE_W'($urandom());
            hi = RANGE_W'($urandom());
         end
         1: begin
            lo = RANGE_W'($urandom());
            hi = (lo > 16'hFFD7) ? 16'hFFFF : lo + RANGE_W'($urandom_range(40));
         end
         2: begin
            lo = '0;
            hi = '1;
         end
         3: begin
            lo = RANGE_W'($urandom_range(65535, 1));
            hi = RANGE_W'($urandom_range(lo - 1, 0));
         end
         default: begin
            lo = '0;
            hi = RANGE_W'($urandom_range(1000));
         end
      endcase
      write_reg(CSR_RANGE_MIN, {16'($urandom()), lo});
      write_reg(CSR_RANGE_MAX, {16'($urandom()), hi});
      if ($urandom_range(99) < 20) write_reg(CSR_UNUSED_HI, $urandom());
      end_writes();
   endtask

   // Stimulus and verdict.
   initial begin
      int sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Before any seed every draw returns zero; a blank returns nothing.
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      settle();

      // Writes past the register list must not mark the block seeded.
      write_reg(CSR_UNUSED_LO, '1);
      write_reg(CSR_UNUSED_HI, 32'h1234_5678);
      end_writes();
      send_draws(1);
      settle();

      // Long register seeded alone, reset taps and range.
      write_reg(CSR_SEED_LONG, '1);
      end_writes();
      send_draws(3);
      settle();

      // Full span of the range.
      write_reg(CSR_SEED_SHORT, 32'h0000_0001);
      write_reg(CSR_RANGE_MAX, 32'hA5A5_FFFF);
      end_writes();
      send_draws(3);
      settle();

      // Single-value range at the top.
      write_reg(CSR_RANGE_MIN, 32'h0000_FFFF);
      end_writes();
      send_draws(2);
      settle();

      // Inverted range with the largest offset: the sum needs all 17 bits.
      write_reg(CSR_RANGE_MAX, 32'hFFFF_0000);
      end_writes();
      send_draws(3);
      settle();

      write_reg(CSR_RANGE_MIN, 32'h0000_0001);
      write_reg(CSR_RANGE_MAX, 32'h0000_0000);
      end_writes();
      send_draws(2);
      settle();

      // Extreme tap masks and seeds.
      write_reg(CSR_MASK_LONG, '1);
      write_reg(CSR_MASK_SHORT, '0);
      write_reg(CSR_SEED_LONG, 32'h8000_0000);
      write_reg(CSR_SEED_SHORT, '1);
      write_reg(CSR_RANGE_MIN, 32'h0000_0000);
      write_reg(CSR_RANGE_MAX, 32'h0000_0001);
      end_writes();
      send_draws(2);
      settle();

      // All-zero seeds lock both registers at zero.
      write_reg(CSR_SEED_LONG, '0);
      write_reg(CSR_SEED_SHORT, '0);
      write_reg(CSR_MASK_LONG, MASK_LONG_RESET);
      write_reg(CSR_MASK_SHORT, MASK_SHORT_RESET);
      end_writes();
      send_request(1'b1);
      send_request(1'b0);
      settle();

      // Randomised phases; one runs without idling, one meets the long stall.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         randomise_settings();
         no_idle <= (phase == BUSY_PHASE);
         sent = 0;
         while (sent < DRAWS_PER_PHASE) begin
            if (phase == STALL_PHASE && sent == 40)
               hold_req <= 1'b1;
            if ($urandom_range(99) < BLANK_PERCENT) begin
               send_request(1'b0);
            end else begin
               send_request(1'b1);
               sent++;
            end
         end
         settle();
      end

      $display("Run covered %0d draws and %0d blank requests over %0d register settings;",
               draws_sent, blanks_sent, settings_used);
      $display("%0d results checked, unseeded, single-value, full and inverted ranges among them.",
               draws_checked);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
